[hw/rtl/wav_header_checker_defines.svh]
// assertion macros of the wav header checker rtl, used by the control fsm
`ifndef WAV_HEADER_CHECKER_DEFINES_SVH
`define WAV_HEADER_CHECKER_DEFINES_SVH

// cond must hold in the same cycle as trig
`define WHC_ASSERT_SAME(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("whc same-cycle check failed");

// cond must hold in the cycle after trig
`define WHC_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("whc next-cycle check failed");

`endif

[hw/rtl/whc_pkg.sv]
// types and constants of the wav header checker
`timescale 1ns / 1ps

package whc_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 32;

	localparam logic [31:0] HDR_MIN     = 32'd44;
	localparam logic [31:0] FMT_LEN     = 32'd16;
	localparam logic [31:0] CHUNK_HDR   = 32'd8;
	localparam logic [31:0] FIRST_CHUNK = 32'd36;
	localparam logic [15:0] FORMAT_PCM  = 16'd1;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// byte offsets at which a little-endian word is complete
	localparam logic [31:0] POS_RIFF_TAG   = 32'd3;
	localparam logic [31:0] POS_RIFF_SIZE  = 32'd7;
	localparam logic [31:0] POS_WAVE_TAG   = 32'd11;
	localparam logic [31:0] POS_FMT_TAG    = 32'd15;
	localparam logic [31:0] POS_FMT_SIZE   = 32'd19;
	localparam logic [31:0] POS_FORMAT     = 32'd21;
	localparam logic [31:0] POS_CHANNELS   = 32'd23;
	localparam logic [31:0] POS_RATE       = 32'd27;
	localparam logic [31:0] POS_AVG_RATE   = 32'd31;
	localparam logic [31:0] POS_ALIGN      = 32'd33;
	localparam logic [31:0] POS_BITS       = 32'd35;
	localparam logic [31:0] POS_CHUNK_TAG  = 32'd39;
	localparam logic [31:0] POS_CHUNK_SIZE = 32'd43;

	// distance from the data chunk start after a list chunk
	localparam logic [31:0] DIST_DATA_TAG  = 32'd3;
	localparam logic [31:0] DIST_DATA_SIZE = 32'd7;

	localparam int unsigned FLAG_RIFF = 0;
	localparam int unsigned FLAG_WAVE = 1;
	localparam int unsigned FLAG_FMT  = 2;
	localparam int unsigned FLAG_DATA = 3;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DIRECT,
		PH_LIST
	} parse_phase_t;

	typedef enum logic [3:0] {
		ERR_OK,
		ERR_SHORT,
		ERR_RIFF,
		ERR_WAVE,
		ERR_FMT,
		ERR_FMTSIZE,
		ERR_LIST,
		ERR_ROOM,
		ERR_DATATAG,
		ERR_PCM,
		ERR_RATE,
		ERR_ZEROSAMPLE,
		ERR_RIFFSIZE,
		ERR_DATASIZE
	} err_code_t;

	typedef enum logic [2:0] {
		S_RUN,
		S_MUL,
		S_CHECK,
		S_DIV,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic compute;
		logic judge;
		logic div_start;
		logic finish;
	} whc_cmd_t;

	typedef struct packed {
		logic pass;
		logic div_done;
	} whc_status_t;

endpackage

[hw/rtl/whc_div.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module whc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quotient,
	output logic        done
);

	localparam int unsigned STEPS  = 32;
	localparam int unsigned STEP_W = $clog2(STEPS);

	logic [31:0]       rem_q;
	logic [31:0]       quo_q;
	logic [31:0]       den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [32:0]       shifted;
	logic [32:0]       diff;
	logic              fits;

	always_comb begin
		shifted = {rem_q, quo_q[31]};
		diff    = shifted - {1'b0, den_q};
		fits    = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(STEPS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[hw/rtl/whc_datapath.sv]
// field capture, header checks and result register of the wav header checker
`timescale 1ns / 1ps

module whc_datapath #(
	parameter int unsigned LENGTH_BITS = whc_pkg::LENGTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            file_byte,
	input  whc_pkg::whc_cmd_t     cmd,
	output whc_pkg::whc_status_t  status,
	output logic [3:0]            error_code,
	output logic [15:0]           channels,
	output logic [31:0]           sample_rate,
	output logic [15:0]           bits_per_sample,
	output logic [31:0]           sample_count,
	output logic [31:0]           data_bytes,
	output logic [31:0]           chunk_offset
);

	logic [LENGTH_BITS-1:0] byte_count_q;
	logic                   not_sat;
	logic [31:0]            pos;
	logic [31:0]            word;
	logic [31:0]            pay_dist;
	logic                   list_hit;

	logic [31:0]              tag_shift_q;
	logic [3:0]               tag_flags_q;
	whc_pkg::parse_phase_t    phase_q;
	logic [31:0]              riff_size_q;
	logic [31:0]              fmt_size_q;
	logic [15:0]              format_q;
	logic [15:0]              channel_q;
	logic [31:0]              rate_q;
	logic [31:0]              avg_rate_q;
	logic [15:0]              align_q;
	logic [15:0]              bits_q;
	logic [31:0]              list_len_q;
	logic [31:0]              pay_off_q;
	logic [31:0]              pay_size_q;

	logic [31:0] rate_prod;
	logic [31:0] frame_prod;
	logic [31:0] off_sel;
	logic [32:0] rem_full;

	logic [31:0] avg_prod_s1;
	logic [28:0] frame_s1;
	logic [31:0] len_s1;
	logic [31:0] off_s1;
	logic        len_lt_off_s1;
	logic [31:0] rem_s1;
	logic [31:0] len_m8_s1;
	logic [31:0] len_m44_s1;

	whc_pkg::err_code_t err_next;
	whc_pkg::err_code_t err_q;
	logic               err_ok;

	logic [31:0] quotient;
	logic        div_done;

	always_comb begin
		not_sat  = ~(&byte_count_q);
		pos      = 32'(byte_count_q);
		word     = {file_byte, tag_shift_q[31:8]};
		pay_dist = pos - pay_off_q;
		list_hit = (phase_q == whc_pkg::PH_LIST) && (pos >= whc_pkg::HDR_MIN) &&
			(pos >= pay_off_q);
	end

	// byte capture, cleared again once the verdict is handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			tag_shift_q  <= '0;
			tag_flags_q  <= '0;
			phase_q      <= whc_pkg::PH_HEADER;
			riff_size_q  <= '0;
			fmt_size_q   <= '0;
			format_q     <= '0;
			channel_q    <= '0;
			rate_q       <= '0;
			avg_rate_q   <= '0;
			align_q      <= '0;
			bits_q       <= '0;
			list_len_q   <= '0;
			pay_off_q    <= whc_pkg::FIRST_CHUNK;
			pay_size_q   <= '0;
		end else if (cmd.finish) begin
			byte_count_q <= '0;
			tag_shift_q  <= '0;
			tag_flags_q  <= '0;
			phase_q      <= whc_pkg::PH_HEADER;
			riff_size_q  <= '0;
			fmt_size_q   <= '0;
			format_q     <= '0;
			channel_q    <= '0;
			rate_q       <= '0;
			avg_rate_q   <= '0;
			align_q      <= '0;
			bits_q       <= '0;
			list_len_q   <= '0;
			pay_off_q    <= whc_pkg::FIRST_CHUNK;
			pay_size_q   <= '0;
		end else if (cmd.capture && not_sat) begin
			byte_count_q <= byte_count_q + LENGTH_BITS'(1);
			tag_shift_q  <= word;
			case (pos)
				whc_pkg::POS_RIFF_TAG: begin
					if (word == whc_pkg::TAG_RIFF) tag_flags_q[whc_pkg::FLAG_RIFF] <= 1'b1;
				end
				whc_pkg::POS_RIFF_SIZE: riff_size_q <= word;
				whc_pkg::POS_WAVE_TAG: begin
					if (word == whc_pkg::TAG_WAVE) tag_flags_q[whc_pkg::FLAG_WAVE] <= 1'b1;
				end
				whc_pkg::POS_FMT_TAG: begin
					if (word == whc_pkg::TAG_FMT) tag_flags_q[whc_pkg::FLAG_FMT] <= 1'b1;
				end
				whc_pkg::POS_FMT_SIZE: fmt_size_q <= word;
				whc_pkg::POS_FORMAT:   format_q   <= word[31:16];
				whc_pkg::POS_CHANNELS: channel_q  <= word[31:16];
				whc_pkg::POS_RATE:     rate_q     <= word;
				whc_pkg::POS_AVG_RATE: avg_rate_q <= word;
				whc_pkg::POS_ALIGN:    align_q    <= word[31:16];
				whc_pkg::POS_BITS:     bits_q     <= word[31:16];
				whc_pkg::POS_CHUNK_TAG: begin
					if (word == whc_pkg::TAG_LIST) begin
						phase_q <= whc_pkg::PH_LIST;
					end else begin
						phase_q <= whc_pkg::PH_DIRECT;
						if (word == whc_pkg::TAG_DATA) tag_flags_q[whc_pkg::FLAG_DATA] <= 1'b1;
					end
				end
				whc_pkg::POS_CHUNK_SIZE: begin
					if (phase_q == whc_pkg::PH_LIST) begin
						list_len_q <= word;
						pay_off_q  <= whc_pkg::HDR_MIN + word;
					end else begin
						pay_size_q <= word;
					end
				end
				default: begin
					// data chunk header behind a list chunk
					if (list_hit) begin
						if (pay_dist == whc_pkg::DIST_DATA_TAG && word == whc_pkg::TAG_DATA) begin
							tag_flags_q[whc_pkg::FLAG_DATA] <= 1'b1;
						end
						if (pay_dist == whc_pkg::DIST_DATA_SIZE) pay_size_q <= word;
					end
				end
			endcase
		end
	end

	always_comb begin
		rate_prod  = rate_q * 32'(align_q);
		frame_prod = channel_q * bits_q;
		off_sel    = (phase_q == whc_pkg::PH_LIST) ? pay_off_q : whc_pkg::FIRST_CHUNK;
		rem_full   = {1'b0, pos} - {1'b0, off_sel};
	end

	// products and length differences, registered ahead of the compares
	always_ff @(posedge clk) begin
		if (cmd.compute) begin
			avg_prod_s1   <= rate_prod;
			frame_s1      <= frame_prod[31:3];
			len_s1        <= pos;
			off_s1        <= off_sel;
			len_lt_off_s1 <= rem_full[32];
			rem_s1        <= rem_full[31:0];
			len_m8_s1     <= pos - whc_pkg::CHUNK_HDR;
			len_m44_s1    <= pos - whc_pkg::HDR_MIN;
		end
	end

	// checks in priority order, from too-short file down to data size; first failure wins
	always_comb begin
		if (len_s1 < whc_pkg::HDR_MIN) begin
			err_next = whc_pkg::ERR_SHORT;
		end else if (!tag_flags_q[whc_pkg::FLAG_RIFF]) begin
			err_next = whc_pkg::ERR_RIFF;
		end else if (!tag_flags_q[whc_pkg::FLAG_WAVE]) begin
			err_next = whc_pkg::ERR_WAVE;
		end else if (!tag_flags_q[whc_pkg::FLAG_FMT]) begin
			err_next = whc_pkg::ERR_FMT;
		end else if (fmt_size_q != whc_pkg::FMT_LEN) begin
			err_next = whc_pkg::ERR_FMTSIZE;
		end else if (phase_q == whc_pkg::PH_LIST && len_m44_s1 < list_len_q) begin
			err_next = whc_pkg::ERR_LIST;
		end else if (len_lt_off_s1 || rem_s1 < whc_pkg::CHUNK_HDR) begin
			err_next = whc_pkg::ERR_ROOM;
		end else if (!tag_flags_q[whc_pkg::FLAG_DATA]) begin
			err_next = whc_pkg::ERR_DATATAG;
		end else if (format_q != whc_pkg::FORMAT_PCM) begin
			err_next = whc_pkg::ERR_PCM;
		end else if (avg_rate_q != avg_prod_s1) begin
			err_next = whc_pkg::ERR_RATE;
		end else if (frame_s1 == '0) begin
			err_next = whc_pkg::ERR_ZEROSAMPLE;
		end else if (riff_size_q > len_m8_s1) begin
			err_next = whc_pkg::ERR_RIFFSIZE;
		end else if (({1'b0, pay_size_q} + {1'b0, whc_pkg::CHUNK_HDR}) > {1'b0, rem_s1}) begin
			err_next = whc_pkg::ERR_DATASIZE;
		end else begin
			err_next = whc_pkg::ERR_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.judge) err_q <= err_next;
	end

	whc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (pay_size_q),
		.divisor  ({3'b000, frame_s1}),
		.quotient (quotient),
		.done     (div_done)
	);

	assign status = '{pass: (err_next == whc_pkg::ERR_OK), div_done: div_done};
	assign err_ok = (err_q == whc_pkg::ERR_OK);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			error_code      <= err_q;
			channels        <= err_ok ? channel_q  : '0;
			sample_rate     <= err_ok ? rate_q     : '0;
			bits_per_sample <= err_ok ? bits_q     : '0;
			sample_count    <= err_ok ? quotient   : '0;
			data_bytes      <= err_ok ? pay_size_q : '0;
			chunk_offset    <= err_ok ? off_s1     : '0;
		end
	end

endmodule

[hw/rtl/whc_ctrl.sv]
// sequencing state machine of the wav header checker
`timescale 1ns / 1ps
`include "wav_header_checker_defines.svh"

module whc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic                 is_last,
	output logic                 byte_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	output whc_pkg::whc_cmd_t    cmd,
	input  whc_pkg::whc_status_t status
);

	whc_pkg::ctrl_state_t state_q;
	whc_pkg::ctrl_state_t state_d;
	logic                 out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= whc_pkg::S_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			whc_pkg::S_RUN: begin
				if (byte_valid) begin
					cmd.capture = 1'b1;
					if (is_last) state_d = whc_pkg::S_MUL;
				end
			end
			whc_pkg::S_MUL: begin
				cmd.compute = 1'b1;
				state_d     = whc_pkg::S_CHECK;
			end
			whc_pkg::S_CHECK: begin
				cmd.judge = 1'b1;
				if (status.pass) begin
					cmd.div_start = 1'b1;
					state_d       = whc_pkg::S_DIV;
				end else begin
					state_d = whc_pkg::S_DONE;
				end
			end
			whc_pkg::S_DIV: begin
				if (status.div_done) state_d = whc_pkg::S_DONE;
			end
			whc_pkg::S_DONE: begin
				// wait for the result register to free up
				if (!out_valid_q || !result_stall) begin
					cmd.finish = 1'b1;
					state_d    = whc_pkg::S_RUN;
				end
			end
			default: state_d = whc_pkg::S_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign byte_stall   = (state_q != whc_pkg::S_RUN);
	assign result_valid = out_valid_q;

	`WHC_ASSERT_NEXT(a_last_blocks_input, byte_valid && !byte_stall && is_last, byte_stall)
	`WHC_ASSERT_NEXT(a_finish_shows_result, cmd.finish, result_valid)
	`WHC_ASSERT_SAME(a_no_overwrite, cmd.finish, !(result_valid && result_stall))
	`WHC_ASSERT_SAME(a_div_done_in_div, status.div_done, state_q == whc_pkg::S_DIV)

endmodule

[hw/rtl/wav_header_checker.sv]
// top level of the wav header checker
`timescale 1ns / 1ps

// Streaming WAV/RIFF PCM header checker. File bytes are taken one per cycle on
// file_byte while byte_stall is low, with is_last on the final byte; one verdict
// follows each final byte. After the final transfer the byte input stalls while
// the header is judged: first the products are registered, then the ordered
// checks run, then on success the bit-serial divider forms the sample count and
// signals completion, and last the verdict is handed over. The input is held
// further if the previous verdict is still waiting in the result register.
// Verdicts sit in that register until taken, so the next file can stream in
// meanwhile. Files longer than 2^LENGTH_BITS - 1 bytes are judged at that
// saturated length.
module wav_header_checker #(
	parameter int unsigned LENGTH_BITS = whc_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  file_byte,
	input  logic        is_last,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [3:0]  error_code,
	output logic [15:0] channels,
	output logic [31:0] sample_rate,
	output logic [15:0] bits_per_sample,
	output logic [31:0] sample_count,
	output logic [31:0] data_bytes,
	output logic [31:0] chunk_offset
);

	whc_pkg::whc_cmd_t    cmd;
	whc_pkg::whc_status_t status;

	whc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.is_last      (is_last),
		.byte_stall   (byte_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

	whc_datapath #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.file_byte       (file_byte),
		.cmd             (cmd),
		.status          (status),
		.error_code      (error_code),
		.channels        (channels),
		.sample_rate     (sample_rate),
		.bits_per_sample (bits_per_sample),
		.sample_count    (sample_count),
		.data_bytes      (data_bytes),
		.chunk_offset    (chunk_offset)
	);

endmodule
